// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLKRST(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Assertion on the module's own clk and arst_n.
`define ASSERT_DEFAULT(label, prop, msg) \
	`ASSERT_CLKRST(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/rvde_pkg.sv =====
// ----------------------------------------------------------------------------
// rvde_pkg
// Types and encodings for the RV32I decode and execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvde_pkg;

	// major opcodes
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// ALU funct3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch funct3
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// load / store funct3
	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;
	localparam logic [2:0] F3_SB  = 3'd0;
	localparam logic [2:0] F3_SH  = 3'd1;
	localparam logic [2:0] F3_SW  = 3'd2;

	localparam logic [31:0] HALT_ADDR_RESET = 32'h0003_0004;
	localparam logic [31:0] JALR_MASK       = 32'hFFFF_FFFE;
	localparam logic [31:0] INSN_BYTES      = 32'd4;

	typedef enum logic [3:0] {
		MEM_NONE = 4'd0,
		MEM_LB   = 4'd1,
		MEM_LH   = 4'd2,
		MEM_LW   = 4'd3,
		MEM_LBU  = 4'd4,
		MEM_LHU  = 4'd5,
		MEM_SB   = 4'd6,
		MEM_SH   = 4'd7,
		MEM_SW   = 4'd8
	} mem_op_t;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] rs1_value;
		logic [31:0] rs2_value;
		logic [31:0] pc;
		logic [31:0] predicted_pc;
	} rvde_in_t;

	typedef struct packed {
		logic [4:0]  dest_reg;
		logic        write_reg;
		logic [31:0] result;
		logic [31:0] mem_address;
		logic [31:0] store_data;
		mem_op_t     mem_op;
		logic [31:0] next_pc;
		logic        redirect;
		logic        illegal;
		logic        halt;
	} rvde_out_t;

endpackage

// ===== rtl/rvde_if.sv =====
// ----------------------------------------------------------------------------
// rvde_in_if / rvde_out_if
// Valid/ready channels for instruction words and execute results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvde_in_if;
	import rvde_pkg::*;

	logic     valid;
	logic     ready;
	rvde_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rvde_out_if;
	import rvde_pkg::*;

	logic      valid;
	logic      ready;
	rvde_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rvde_exec.sv =====
// ----------------------------------------------------------------------------
// rvde_exec
// Combinational decode, ALU, address and branch resolution for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvde_exec (
	input  rvde_pkg::rvde_in_t  in_word,
	input  logic [31:0]         halt_address,
	output rvde_pkg::rvde_out_t out_word
);
	import rvde_pkg::*;

	logic [31:0] ins, a, b, pc, pc_plus4;
	logic [6:0]  op, f7;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
	logic [31:0] alu_b, alu_res, ls_addr, br_target;
	logic [4:0]  sh;
	logic        alu_alt, lt_s, lt_u, taken;
	logic        ill, wr, redir, halt;
	logic [31:0] res, addr, sdata, npc;
	mem_op_t     mop;

	assign ins      = in_word.instruction;
	assign a        = in_word.rs1_value;
	assign b        = in_word.rs2_value;
	assign pc       = in_word.pc;
	assign pc_plus4 = pc + INSN_BYTES;

	assign op = ins[6:0];
	assign rd = ins[11:7];
	assign f3 = ins[14:12];
	assign f7 = ins[31:25];

	assign imm_i = {{20{ins[31]}}, ins[31:20]};
	assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
	assign imm_u = {ins[31:12], 12'h000};

	// OP-IMM shifts take shamt from imm_i[4:0], which is ins[24:20]
	assign alu_b   = (op == OPC_OP) ? b : imm_i;
	assign alu_alt = (op == OPC_OP) ? (f7 == F7_ALT) : ((f3 == F3_SR) && (f7 == F7_ALT));
	assign sh      = alu_b[4:0];

	assign lt_s = $signed(a) < $signed(alu_b);
	assign lt_u = a < alu_b;

	always_comb begin
		unique case (f3)
			F3_ADD:  alu_res = alu_alt ? (a - alu_b) : (a + alu_b);
			F3_SLL:  alu_res = a << sh;
			F3_SLT:  alu_res = {31'd0, lt_s};
			F3_SLTU: alu_res = {31'd0, lt_u};
			F3_XOR:  alu_res = a ^ alu_b;
			F3_SR:   alu_res = alu_alt ? 32'($signed(a) >>> sh) : (a >> sh);
			F3_OR:   alu_res = a | alu_b;
			default: alu_res = a & alu_b;
		endcase
	end

	assign ls_addr   = a + ((op == OPC_STORE) ? imm_s : imm_i);
	assign br_target = pc + imm_b;

	always_comb begin
		unique case (f3)
			F3_BEQ:  taken = (a == b);
			F3_BNE:  taken = (a != b);
			F3_BLT:  taken = ($signed(a) < $signed(b));
			F3_BGE:  taken = !($signed(a) < $signed(b));
			F3_BLTU: taken = (a < b);
			F3_BGEU: taken = !(a < b);
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		ill   = 1'b0;
		wr    = 1'b0;
		redir = 1'b0;
		halt  = 1'b0;
		res   = '0;
		addr  = '0;
		sdata = '0;
		mop   = MEM_NONE;
		npc   = pc_plus4;
		unique case (op)
			OPC_OP: begin
				if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
					res = alu_res;
					wr  = 1'b1;
				end else begin
					ill = 1'b1;
				end
			end
			OPC_OP_IMM: begin
				if ((f3 == F3_SLL && f7 != F7_BASE) ||
						(f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) begin
					ill = 1'b1;
				end else begin
					res = alu_res;
					wr  = 1'b1;
				end
			end
			OPC_LOAD: begin
				wr   = 1'b1;
				addr = ls_addr;
				unique case (f3)
					F3_LB:   mop = MEM_LB;
					F3_LH:   mop = MEM_LH;
					F3_LW:   mop = MEM_LW;
					F3_LBU:  mop = MEM_LBU;
					F3_LHU:  mop = MEM_LHU;
					default: ill = 1'b1;
				endcase
			end
			OPC_STORE: begin
				addr  = ls_addr;
				sdata = b;
				halt  = (ls_addr == halt_address);
				unique case (f3)
					F3_SB:   mop = MEM_SB;
					F3_SH:   mop = MEM_SH;
					F3_SW:   mop = MEM_SW;
					default: ill = 1'b1;
				endcase
			end
			OPC_BRANCH: begin
				if (f3 == 3'd2 || f3 == 3'd3) begin
					ill = 1'b1;
				end else begin
					npc   = taken ? br_target : pc_plus4;
					redir = (npc != in_word.predicted_pc);
				end
			end
			OPC_JAL: begin
				res = pc_plus4;
				npc = pc + imm_j;
				wr  = 1'b1;
			end
			OPC_JALR: begin
				if (f3 != 3'd0) begin
					ill = 1'b1;
				end else begin
					res   = pc_plus4;
					npc   = ls_addr & JALR_MASK;
					redir = 1'b1;
					wr    = 1'b1;
				end
			end
			OPC_LUI: begin
				res = imm_u;
				wr  = 1'b1;
			end
			OPC_AUIPC: begin
				res = pc + imm_u;
				wr  = 1'b1;
			end
			default: ill = 1'b1;
		endcase

		// an illegal word leaves nothing behind but the flag and pc+4
		if (ill) begin
			wr    = 1'b0;
			redir = 1'b0;
			halt  = 1'b0;
			res   = '0;
			addr  = '0;
			sdata = '0;
			mop   = MEM_NONE;
			npc   = pc_plus4;
		end
	end

	always_comb begin
		out_word.dest_reg    = wr ? rd : 5'd0;
		out_word.write_reg   = wr && (rd != 5'd0);
		out_word.result      = res;
		out_word.mem_address = addr;
		out_word.store_data  = sdata;
		out_word.mem_op      = mop;
		out_word.next_pc     = npc;
		out_word.redirect    = redir;
		out_word.illegal     = ill;
		out_word.halt        = halt;
	end

endmodule

// ===== rtl/rv32i_decode_execute.sv =====
// ----------------------------------------------------------------------------
// rv32i_decode_execute
// RV32I decode and execute: takes an instruction word with its pc, the
// predicted next pc and both source register values, and returns the
// register write, ALU or link result, load/store address and kind, the
// resolved next pc with a redirect flag, an illegal-encoding flag and a halt
// flag for a store to the programmed halt address. One word is accepted every
// cycle while the result channel accepts; each accepted word is held in the
// input register, then passes once through decode/ALU logic into the result
// register. Backpressure on the result channel holds both stages, and the
// input stays ready while either stage has room. The halt address resets to
// 0x30004 and is written through halt_address_we / halt_address_wdata; the
// user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rv32i_decode_execute (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              halt_address_we,
	input  logic [31:0]       halt_address_wdata,
	rvde_in_if.sink           instr_ch,
	rvde_out_if.source        result_ch
);
	import rvde_pkg::*;

	logic        in_valid_s1;
	rvde_in_t    in_word_s1;
	logic        res_valid_s2;
	rvde_out_t   res_word_s2;
	rvde_out_t   exec_word;
	logic [31:0] halt_address_q;
	logic        s2_load;

	assign s2_load        = !res_valid_s2 || result_ch.ready;
	assign instr_ch.ready = !in_valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_address_q <= HALT_ADDR_RESET;
		end else if (halt_address_we) begin
			halt_address_q <= halt_address_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (instr_ch.ready) begin
				in_valid_s1 <= instr_ch.valid;
			end
			if (s2_load) begin
				res_valid_s2 <= in_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (instr_ch.ready && instr_ch.valid) begin
			in_word_s1 <= instr_ch.data;
		end
		if (s2_load && in_valid_s1) begin
			res_word_s2 <= exec_word;
		end
	end

	rvde_exec u_exec (
		.in_word      (in_word_s1),
		.halt_address (halt_address_q),
		.out_word     (exec_word)
	);

	assign result_ch.valid = res_valid_s2;
	assign result_ch.data  = res_word_s2;

	// input only stalls with both stages full
	`ASSERT_DEFAULT(a_stall_full, !instr_ch.ready |-> (in_valid_s1 && res_valid_s2), "input stalled with a free stage")
	`ASSERT_DEFAULT(a_illegal_clean, (res_valid_s2 && res_word_s2.illegal) |-> (!res_word_s2.redirect && !res_word_s2.halt && res_word_s2.mem_op == MEM_NONE && !res_word_s2.write_reg), "illegal word with side effects")
	`ASSERT_DEFAULT(a_halt_store, (res_valid_s2 && res_word_s2.halt) |-> (res_word_s2.mem_op == MEM_SB || res_word_s2.mem_op == MEM_SH || res_word_s2.mem_op == MEM_SW), "halt without a store")
	`ASSERT_DEFAULT(a_wr_nonzero, (res_valid_s2 && res_word_s2.write_reg) |-> (res_word_s2.dest_reg != 5'd0), "write to x0")

endmodule

// ===== tb/tb_rv32i_decode_execute.sv =====
// ----------------------------------------------------------------------------
// tb_rv32i_decode_execute
// Self-checking bench for the RV32I decode/execute block. A driver feeds
// instruction words from a queue; every accepted word is run through a local
// decode/execute predictor and the expected result is queued. The monitor
// compares each returned word in order against that queue. A directed set
// (operand and immediate extremes, halt hits, redirects, illegal encodings)
// is followed by random phases under several halt address settings, with
// random stalls on both channels outside one steady phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rv32i_decode_execute;
	import rvde_pkg::*;

	// encodings the block must reject, and the legal JALR funct3
	localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM   = 7'h73;
	localparam logic [2:0] F3_JALR      = 3'd0;
	localparam logic [2:0] F3_LD_RSVD_A = 3'd3;
	localparam logic [2:0] F3_LD_RSVD_B = 3'd6;
	localparam logic [2:0] F3_LD_RSVD_C = 3'd7;
	localparam logic [2:0] F3_BR_RSVD_A = 3'd2;
	localparam logic [2:0] F3_BR_RSVD_B = 3'd3;

	localparam int PHASES          = 5;
	localparam int WORDS_PER_PHASE = 285;

	logic        clk;
	logic        arst_n;
	logic        halt_address_we;
	logic [31:0] halt_address_wdata;

	rvde_in_if  instr_ch ();
	rvde_out_if result_ch ();

	rv32i_decode_execute dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.halt_address_we   (halt_address_we),
		.halt_address_wdata(halt_address_wdata),
		.instr_ch          (instr_ch),
		.result_ch         (result_ch)
	);

	rvde_in_t    pending_words[$];
	rvde_out_t   expected_results[$];
	logic [31:0] halt_shadow;
	logic        steady;
	int          mismatch_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic idle_now();
		return !steady && ($urandom_range(99) < 14);
	endfunction

	function automatic logic [31:0] alu_out(logic [2:0] f3, logic alt, logic [31:0] a,
			logic [31:0] b);
		logic signed [31:0] sa;
		logic [4:0]         sh;
		sa = a;
		sh = b[4:0];
		case (f3)
			F3_ADD:  return alt ? a - b : a + b;
			F3_SLL:  return a << sh;
			F3_SLT:  return {31'b0, $signed(a) < $signed(b)};
			F3_SLTU: return {31'b0, a < b};
			F3_XOR:  return a ^ b;
			F3_SR: begin
				if (alt)
					return sa >>> sh;
				return a >> sh;
			end
			F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	function automatic rvde_out_t predict_execute(rvde_in_t w, logic [31:0] halt_at);
		rvde_out_t   r;
		logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, link;
		logic [6:0]  opc, f7;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic        writes, bad, taken;
		ins   = w.instruction;
		a     = w.rs1_value;
		b     = w.rs2_value;
		opc   = ins[6:0];
		rd    = ins[11:7];
		f3    = ins[14:12];
		f7    = ins[31:25];
		imm_i = {{20{ins[31]}}, ins[31:20]};
		imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
		imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
		imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
		link  = w.pc + INSN_BYTES;
		r         = '0;
		r.mem_op  = MEM_NONE;
		r.next_pc = link;
		writes    = 1'b0;
		bad       = 1'b0;
		taken     = 1'b0;
		case (opc)
			OPC_OP: begin
				if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
					r.result = alu_out(f3, f7 == F7_ALT, a, b);
					writes   = 1'b1;
				end else
					bad = 1'b1;
			end
			OPC_OP_IMM: begin
				if ((f3 == F3_SLL && f7 != F7_BASE) ||
						(f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT))
					bad = 1'b1;
				else begin
					// shifts take the 5-bit shamt, not the whole immediate
					r.result = alu_out(f3, f3 == F3_SR && f7 == F7_ALT, a,
						(f3 == F3_SLL || f3 == F3_SR) ? {27'b0, ins[24:20]} : imm_i);
					writes = 1'b1;
				end
			end
			OPC_LOAD: begin
				case (f3)
					F3_LB:   r.mem_op = MEM_LB;
					F3_LH:   r.mem_op = MEM_LH;
					F3_LW:   r.mem_op = MEM_LW;
					F3_LBU:  r.mem_op = MEM_LBU;
					F3_LHU:  r.mem_op = MEM_LHU;
					default: bad = 1'b1;
				endcase
				if (!bad) begin
					r.mem_address = a + imm_i;
					writes        = 1'b1;
				end
			end
			OPC_STORE: begin
				case (f3)
					F3_SB:   r.mem_op = MEM_SB;
					F3_SH:   r.mem_op = MEM_SH;
					F3_SW:   r.mem_op = MEM_SW;
					default: bad = 1'b1;
				endcase
				if (!bad) begin
					r.mem_address = a + imm_s;
					r.store_data  = b;
					r.halt        = (r.mem_address == halt_at);
				end
			end
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ:  taken = (a == b);
					F3_BNE:  taken = (a != b);
					F3_BLT:  taken = $signed(a) < $signed(b);
					F3_BGE:  taken = !($signed(a) < $signed(b));
					F3_BLTU: taken = (a < b);
					F3_BGEU: taken = (a >= b);
					default: bad = 1'b1;
				endcase
				if (!bad) begin
					r.next_pc  = taken ? w.pc + imm_b : link;
					r.redirect = (r.next_pc != w.predicted_pc);
				end
			end
			OPC_JAL: begin
				// resolved at fetch, so no redirect
				r.result  = link;
				r.next_pc = w.pc + imm_j;
				writes    = 1'b1;
			end
			OPC_JALR: begin
				if (f3 != F3_JALR)
					bad = 1'b1;
				else begin
					r.result   = link;
					r.next_pc  = (a + imm_i) & JALR_MASK;
					r.redirect = 1'b1;
					writes     = 1'b1;
				end
			end
			OPC_LUI: begin
				r.result = {ins[31:12], 12'b0};
				writes   = 1'b1;
			end
			OPC_AUIPC: begin
				r.result = w.pc + {ins[31:12], 12'b0};
				writes   = 1'b1;
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin
			r         = '0;
			r.mem_op  = MEM_NONE;
			r.next_pc = link;
			r.illegal = 1'b1;
		end else if (writes) begin
			r.dest_reg  = rd;
			r.write_reg = (rd != 5'd0);
		end
		return r;
	endfunction

	function automatic string show(rvde_out_t r);
		return $sformatf("rd=%0d we=%0b res=%h addr=%h sd=%h op=%0d npc=%h rdr=%0b ill=%0b hlt=%0b",
			r.dest_reg, r.write_reg, r.result, r.mem_address, r.store_data, r.mem_op,
			r.next_pc, r.redirect, r.illegal, r.halt);
	endfunction

	task automatic note_mismatch(string what, rvde_out_t want, rvde_out_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s\n  expected %s\n  actual   %s", $realtime, what, show(want),
				show(got));
	endtask

	// driver: next word goes out once the current one has been taken, unless idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_ch.valid <= 1'b0;
			instr_ch.data  <= '0;
		end else if (!instr_ch.valid || instr_ch.ready) begin
			if (pending_words.size() != 0 && !idle_now()) begin
				instr_ch.valid <= 1'b1;
				instr_ch.data  <= pending_words.pop_front();
			end else
				instr_ch.valid <= 1'b0;
		end
	end

	// monitor: predicts on acceptance, checks returned words in order
	always @(posedge clk or negedge arst_n) begin : result_check
		rvde_out_t want;
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else begin
			if (instr_ch.valid && instr_ch.ready)
				expected_results.push_back(predict_execute(instr_ch.data, halt_shadow));
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0)
					note_mismatch("word with nothing expected", '0, result_ch.data);
				else begin
					want = expected_results.pop_front();
					if (result_ch.data !== want)
						note_mismatch("result mismatch", want, result_ch.data);
				end
			end
			result_ch.ready <= !idle_now();
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [6:0] opc);
		return {f7, 5'd3, 5'd2, f3, 5'd1, opc};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [2:0] f3, logic [4:0] rd,
			logic [6:0] opc);
		return {imm, 5'd2, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [2:0] f3);
		return {imm[11:5], 5'd3, 5'd2, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [2:0] f3);
		return {imm[12], imm[10:5], 5'd3, 5'd2, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	task automatic queue_word(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
			logic [31:0] pc, logic [31:0] pred);
		rvde_in_t w;
		w.instruction  = ins;
		w.rs1_value    = a;
		w.rs2_value    = b;
		w.pc           = pc;
		w.predicted_pc = pred;
		pending_words.push_back(w);
	endtask

	// mostly well-formed instructions with random fields, some bad codes and noise
	function automatic rvde_in_t make_random_word(logic [31:0] halt_at);
		rvde_in_t    w;
		logic [31:0] ins, imm;
		int unsigned pick;
		ins            = $urandom;
		w.rs1_value    = pick_operand();
		w.rs2_value    = pick_operand();
		w.pc           = $urandom;
		w.predicted_pc = $urandom_range(1) ? w.pc + INSN_BYTES : $urandom;
		pick           = $urandom_range(99);
		if (pick < 15) begin
			ins[6:0]   = OPC_OP;
			ins[31:25] = ((ins[14:12] == F3_ADD || ins[14:12] == F3_SR) && ins[25]) ?
				F7_ALT : F7_BASE;
		end else if (pick < 30) begin
			ins[6:0] = OPC_OP_IMM;
			if (ins[14:12] == F3_SLL)
				ins[31:25] = F7_BASE;
			else if (ins[14:12] == F3_SR)
				ins[31:25] = ins[30] ? F7_ALT : F7_BASE;
		end else if (pick < 42) begin
			ins[6:0] = OPC_LOAD;
			case ($urandom_range(4))
				0:       ins[14:12] = F3_LB;
				1:       ins[14:12] = F3_LH;
				2:       ins[14:12] = F3_LW;
				3:       ins[14:12] = F3_LBU;
				default: ins[14:12] = F3_LHU;
			endcase
		end else if (pick < 54) begin
			ins[6:0]   = OPC_STORE;
			ins[14:12] = 3'($urandom_range(F3_SW));
			// aim a quarter of the stores at the halt address
			if ($urandom_range(3) == 0) begin
				imm         = {{20{ins[31]}}, ins[31:25], ins[11:7]};
				w.rs1_value = halt_at - imm;
			end
		end else if (pick < 72) begin
			ins[6:0] = OPC_BRANCH;
			case ($urandom_range(5))
				0:       ins[14:12] = F3_BEQ;
				1:       ins[14:12] = F3_BNE;
				2:       ins[14:12] = F3_BLT;
				3:       ins[14:12] = F3_BGE;
				4:       ins[14:12] = F3_BLTU;
				default: ins[14:12] = F3_BGEU;
			endcase
			if ($urandom_range(2) == 0)
				w.rs2_value = w.rs1_value;
			imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
			case ($urandom_range(2))
				0:       w.predicted_pc = w.pc + INSN_BYTES;
				1:       w.predicted_pc = w.pc + imm;
				default: w.predicted_pc = $urandom;
			endcase
		end else if (pick < 78)
			ins[6:0] = OPC_JAL;
		else if (pick < 84) begin
			ins[6:0]   = OPC_JALR;
			ins[14:12] = F3_JALR;
		end else if (pick < 88)
			ins[6:0] = OPC_LUI;
		else if (pick < 92)
			ins[6:0] = OPC_AUIPC;
		else if (pick < 96) begin
			case ($urandom_range(5))
				0: begin
					ins[6:0] = OPC_OP;
					// odd funct7 is never legal; otherwise alt funct7 on the wrong op
					if (!ins[25]) begin
						ins[31:25] = F7_ALT;
						if (ins[14:12] == F3_ADD || ins[14:12] == F3_SR)
							ins[14:12] = F3_XOR;
					end
				end
				1: begin
					ins[6:0]   = OPC_OP_IMM;
					ins[14:12] = ins[12] ? F3_SLL : F3_SR;
					ins[25]    = 1'b1;
				end
				2: begin
					ins[6:0] = OPC_LOAD;
					case ($urandom_range(2))
						0:       ins[14:12] = F3_LD_RSVD_A;
						1:       ins[14:12] = F3_LD_RSVD_B;
						default: ins[14:12] = F3_LD_RSVD_C;
					endcase
				end
				3: begin
					ins[6:0]   = OPC_STORE;
					ins[14:12] = 3'($urandom_range(7, F3_SW + 1));
				end
				4: begin
					ins[6:0]   = OPC_BRANCH;
					ins[14:12] = ins[12] ? F3_BR_RSVD_B : F3_BR_RSVD_A;
				end
				default: begin
					ins[6:0]   = OPC_JALR;
					ins[14:12] = 3'($urandom_range(7, F3_JALR + 1));
				end
			endcase
		end
		w.instruction = ins;
		return w;
	endfunction

	task automatic wait_idle();
		while (pending_words.size() != 0 || instr_ch.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] setting;
		clk                = 1'b0;
		arst_n             = 1'b0;
		halt_address_we    = 1'b0;
		halt_address_wdata = '0;
		instr_ch.valid     = 1'b0;
		instr_ch.data      = '0;
		result_ch.ready    = 1'b0;
		halt_shadow        = HALT_ADDR_RESET;
		steady             = 1'b0;
		mismatch_count     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// ALU extremes: carry out, borrow, sign bit shifted arithmetically
		queue_word(enc_r(F7_BASE, F3_ADD, OPC_OP), 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h4);
		queue_word(enc_r(F7_ALT, F3_ADD, OPC_OP), 32'h0, 32'h1, 32'h100, 32'h104);
		queue_word(enc_r(F7_ALT, F3_SR, OPC_OP), 32'h8000_0000, 32'hFFFF_FFFF, 32'h200, 32'h0);
		queue_word(enc_i({F7_ALT, 5'd31}, F3_SR, 5'd31, OPC_OP_IMM), 32'h8000_0000, 32'h0,
			32'h300, 32'h304);
		queue_word(enc_i(12'hFFF, F3_SLTU, 5'd0, OPC_OP_IMM), 32'hFFFF_FFFE, 32'h0, 32'h8, 32'hC);
		queue_word(enc_i(12'h800, F3_LW, 5'd5, OPC_LOAD), 32'h0, 32'h0, 32'h10, 32'h14);
		queue_word(enc_i(12'h7FF, F3_LBU, 5'd6, OPC_LOAD), 32'hFFFF_FFFF, 32'h0, 32'h14, 32'h18);
		// stores at, just past, and back onto the halt address
		queue_word(enc_s(12'h000, F3_SW), halt_shadow, 32'hDEAD_BEEF, 32'h18, 32'h1C);
		queue_word(enc_s(12'h001, F3_SB), halt_shadow, 32'hFFFF_FFFF, 32'h1C, 32'h20);
		queue_word(enc_s(12'h800, F3_SH), halt_shadow + 32'h800, 32'h1234, 32'h20, 32'h24);
		// taken backwards and mispredicted; not taken across the top of memory
		queue_word(enc_b(13'h1000, F3_BEQ), 32'h5, 32'h5, 32'h0, 32'h4);
		queue_word(enc_b(13'h0FFE, F3_BNE), 32'h5, 32'h5, 32'hFFFF_FFFC, 32'h0);
		queue_word(enc_b(13'h0008, F3_BLT), 32'h8000_0000, 32'h1, 32'h1000, 32'h1008);
		queue_word(enc_b(13'h0008, F3_BGEU), 32'h8000_0000, 32'h1, 32'h1000, 32'h1004);
		// JAL to x0 with the largest forward offset, prediction ignored
		queue_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL}, 32'h0, 32'h0, 32'h40, 32'h1234);
		// JALR target has bit 0 cleared and wraps to zero
		queue_word(enc_i(12'h001, F3_JALR, 5'd31, OPC_JALR), 32'hFFFF_FFFF, 32'h0, 32'h44, 32'h0);
		queue_word({20'hFFFFF, 5'd0, OPC_LUI}, 32'h0, 32'h0, 32'h48, 32'h4C);
		queue_word({20'h00001, 5'd7, OPC_AUIPC}, 32'h0, 32'h0, 32'hFFFF_F000, 32'hFFFF_F004);
		// unsupported opcodes and function codes
		queue_word({25'h0, OPC_MISC_MEM}, 32'h1, 32'h2, 32'h50, 32'h0);
		queue_word({25'h0, OPC_SYSTEM}, 32'h1, 32'h2, 32'h54, 32'h0);
		queue_word(32'h0000_0000, 32'h0, 32'h0, 32'hFFFF_FFFC, 32'h0);
		queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(enc_r(F7_ALT, F3_SLL, OPC_OP), 32'h1, 32'h1, 32'h58, 32'h5C);
		queue_word(enc_i({F7_ALT, 5'd1}, F3_SLL, 5'd1, OPC_OP_IMM), 32'h1, 32'h0, 32'h5C, 32'h60);
		queue_word(enc_i(12'h0, F3_JALR + 3'd1, 5'd1, OPC_JALR), 32'h100, 32'h0, 32'h60, 32'h64);
		queue_word(enc_i(12'h0, F3_LD_RSVD_A, 5'd1, OPC_LOAD), 32'h100, 32'h0, 32'h64, 32'h68);
		queue_word(enc_s(12'h0, F3_SW + 3'd1), halt_shadow, 32'h5, 32'h68, 32'h6C);
		queue_word(enc_b(13'h8, F3_BR_RSVD_A), 32'h1, 32'h1, 32'h6C, 32'h74);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				// block must be drained before the halt address moves
				wait_idle();
				case (phase)
					1:       setting = 32'h0000_0000;
					2:       setting = 32'hFFFF_FFFF;
					3:       setting = $urandom;
					default: setting = 32'h8000_0000;
				endcase
				@(posedge clk);
				halt_address_we    <= 1'b1;
				halt_address_wdata <= setting;
				@(posedge clk);
				halt_address_we <= 1'b0;
				halt_shadow = setting;
			end
			steady = (phase == 2);
			repeat (WORDS_PER_PHASE)
				pending_words.push_back(make_random_word(halt_shadow));
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("tb_rv32i_decode_execute: PASS");
		else
			$display("tb_rv32i_decode_execute: FAIL");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb_rv32i_decode_execute: FAIL");
		$finish;
	end

endmodule
